>>> design/delimited_field_extractor_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delimited field extractor
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FIELD_EXTRACTOR_CORE_MACROS_SVH
`define DELIMITED_FIELD_EXTRACTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DFE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DFE_ASSERT_IMPL(lbl, ante, cons, msg)
`define DFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/dfe_pkg.sv
// ----------------------------------------------------------------------------
// Delimited field extractor package
// Shared types, codes and constants of the extractor blocks.
// ----------------------------------------------------------------------------
package dfe_pkg;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int MAX_RESULTS     = 32;
  localparam int CFG_IDX_W       = 3;

  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] SPACE   = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_KW_PAT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KW_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SE_PAT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SE_LEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EE_PAT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EE_LEN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SIMPLIFY  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_EDGE = 3'd7;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_DONE      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_KEYWORD = 2'd0,
    PH_START   = 2'd1,
    PH_CONTENT = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PROC, S_CONT, S_PUSH, S_CHECK, S_EDGE_S, S_EDGE_E,
    S_FEND, S_NEXT, S_FLUSH, S_DONE, S_FIN
  } state_e;

  typedef struct packed {
    logic [63:0] kw_pat;
    logic [3:0]  kw_len;
    logic [63:0] se_pat;
    logic [3:0]  se_len;
    logic [63:0] ee_pat;
    logic [3:0]  ee_len;
    logic        simplify;
    logic        keep_edges;
  } dfe_cfg_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } dfe_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ch;
    logic [15:0] count;
  } dfe_res_t;

  typedef struct packed {
    logic     valid;
    logic     fin;
    dfe_res_t res;
  } dfe_emit_t;

  typedef struct packed {
    logic em_ready;
    logic fin_ready;
  } dfe_ack_t;

  function automatic logic is_ws(logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == SPACE);
  endfunction

endpackage

>>> design/delimited_field_extractor_core.sv
// ----------------------------------------------------------------------------
// Delimited field extractor core
// Finds keyword and edge delimited fields in a character stream.
// ----------------------------------------------------------------------------
// Characters enter a two-entry queue and are scanned by a sequencer that
// advances one matching step per cycle while its results are accepted. A
// plain character passes through a sequence of states; each shift of the
// match window, each result and each replayed end edge character adds
// states, so the engine loop, not the queue, sets the rate. Results leave
// through a one-deep hold stage and an output register at up to one per
// cycle, and the last result of each item carries run_last.
module delimited_field_extractor_core #(
  parameter int MAX_PATTERN = dfe_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_BITS  = dfe_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dfe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]                    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     text_char_i,
  input  logic                           stream_last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [7:0]                     out_char_o,
  output logic [15:0]                    fields_found_o,
  output logic                           run_last_o
);
  import dfe_pkg::*;

  dfe_cfg_t  cfg_q, cfg_d;
  logic      item_valid, item_pop;
  dfe_item_t item;
  dfe_emit_t emit;
  dfe_ack_t  ack;
  dfe_res_t  res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KW_PAT:    cfg_d.kw_pat     = cfg_wdata_i;
        CFG_KW_LEN:    cfg_d.kw_len     = cfg_wdata_i[3:0];
        CFG_SE_PAT:    cfg_d.se_pat     = cfg_wdata_i;
        CFG_SE_LEN:    cfg_d.se_len     = cfg_wdata_i[3:0];
        CFG_EE_PAT:    cfg_d.ee_pat     = cfg_wdata_i;
        CFG_EE_LEN:    cfg_d.ee_len     = cfg_wdata_i[3:0];
        CFG_SIMPLIFY:  cfg_d.simplify   = cfg_wdata_i[0];
        CFG_KEEP_EDGE: cfg_d.keep_edges = cfg_wdata_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dfe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_char_i   (text_char_i),
    .stream_last_i (stream_last_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  dfe_engine #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_BITS  (COUNT_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .emit_o       (emit),
    .ack_i        (ack)
  );

  dfe_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .ack_o       (ack),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .run_last_o  (run_last_o)
  );

  assign kind_o         = res.kind;
  assign out_char_o     = res.ch;
  assign fields_found_o = res.count;

`include "delimited_field_extractor_core_macros.svh"

  `DFE_ASSERT_IMPL(a_count_only_on_done, out_valid_o && kind_o != KIND_DONE, fields_found_o == 16'd0, "field count outside a done item")
  `DFE_ASSERT_IMPL(a_char_only_on_char, out_valid_o && kind_o != KIND_CHAR, out_char_o == 8'd0, "character on a non-character result")
  `DFE_ASSERT_IMPL(a_done_is_last, out_valid_o && kind_o == KIND_DONE, run_last_o, "done result not flagged as last")
  `DFE_ASSERT_NEXT(a_fin_flushes_hold, emit.fin && ack.fin_ready, !emit.valid || !item_pop, "result issued while an item closes")

endmodule

>>> design/dfe_front.sv
// ----------------------------------------------------------------------------
// Extractor front end
// Two-entry item queue that decouples the input channel from the scanner.
// ----------------------------------------------------------------------------
module dfe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        text_char_i,
  input  logic              stream_last_i,
  output logic              item_valid_o,
  output dfe_pkg::dfe_item_t item_o,
  input  logic              item_pop_i
);
  import dfe_pkg::*;

  dfe_item_t   mem_q [2];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        push, pop;

  assign in_ready_o   = (fill_q != 2'd2);
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = mem_q[rptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    fill_d = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= '{ch: text_char_i, last: stream_last_i};
    end
  end

endmodule

>>> design/dfe_engine.sv
// ----------------------------------------------------------------------------
// Extractor scanning engine
// Sequencer that runs keyword, start edge and end edge matching one step
// per cycle while results are accepted, and takes one item at a time.
// ----------------------------------------------------------------------------
module dfe_engine #(
  parameter int MAX_PATTERN = dfe_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_BITS  = dfe_pkg::COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dfe_pkg::dfe_cfg_t  cfg_i,
  input  logic               item_valid_i,
  input  dfe_pkg::dfe_item_t item_i,
  output logic               item_pop_o,
  output dfe_pkg::dfe_emit_t emit_o,
  input  dfe_pkg::dfe_ack_t  ack_i
);
  import dfe_pkg::*;

  localparam int PW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int RW = $clog2(MAX_RESULTS + 1);

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        win_q [MAX_PATTERN];
  logic [7:0]        win_d [MAX_PATTERN];
  logic [7:0]        rep_q [MAX_PATTERN];
  logic [7:0]        rep_d [MAX_PATTERN];
  logic [PW-1:0]     cnt_q, cnt_d, rep_len_q, rep_len_d, rep_pos_q, rep_pos_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              ps_q, ps_d, cs_q, cs_d, last_q, last_d;
  logic              rep_act_q, rep_act_d, flush_q, flush_d;
  logic [7:0]        c_q, c_d;
  logic [COUNT_BITS-1:0] fcnt_q, fcnt_d;
  logic [RW-1:0]     res_cnt_q, res_cnt_d;

  logic [PW-1:0]     kl, sl, el, cur_len;
  logic [63:0]       cur_pat;
  logic              dis, pfx, full, capped, adv, e_want;
  logic [7:0]        cc;
  logic              cen, c_ws, c_nul, want_space, want_char, cadv;
  dfe_res_t          e_res;
  logic [31:0]       fc_ext;

  function automatic logic [PW-1:0] eff_len(logic [3:0] len);
    return (len > 4'(MAX_PATTERN)) ? PW'(MAX_PATTERN) : PW'(len);
  endfunction

  assign kl     = eff_len(cfg_i.kw_len);
  assign sl     = eff_len(cfg_i.se_len);
  assign el     = eff_len(cfg_i.ee_len);
  assign dis    = (kl == '0) && (sl == '0);
  assign full   = (cnt_q >= PW'(MAX_PATTERN));
  assign fc_ext = 32'(fcnt_q);

  always_comb begin
    case (phase_q)
      PH_KEYWORD: begin cur_len = kl; cur_pat = cfg_i.kw_pat; end
      PH_START:   begin cur_len = sl; cur_pat = cfg_i.se_pat; end
      default:    begin cur_len = el; cur_pat = cfg_i.ee_pat; end
    endcase
  end

  // Window holds a prefix of the pattern when every held byte matches.
  always_comb begin
    pfx = (cnt_q <= cur_len);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((PW'(i) < cnt_q) && (win_q[i] != cur_pat[8*i +: 8])) begin
        pfx = 1'b0;
      end
    end
  end

  // Content path: a dropped window byte, the current byte or a flushed byte.
  always_comb begin
    cc  = (state_q == S_CONT) ? c_q : win_q[0];
    cen = 1'b0;
    case (state_q)
      S_CONT:  cen = 1'b1;
      S_FLUSH: cen = (cnt_q != '0);
      S_PUSH:  cen = (phase_q == PH_CONTENT) && full;
      S_CHECK: cen = (phase_q == PH_CONTENT) && !pfx;
      default: cen = 1'b0;
    endcase
    c_ws       = is_ws(cc);
    c_nul      = (cc == 8'd0);
    want_space = cen && cfg_i.simplify && !c_nul && !c_ws && ps_q;
    want_char  = cen && !c_nul && !(cfg_i.simplify && c_ws);
  end

  // Result outputs.
  always_comb begin
    e_want = 1'b0;
    e_res  = '{kind: KIND_CHAR, ch: 8'd0, count: 16'd0};
    case (state_q)
      S_CONT, S_FLUSH, S_PUSH, S_CHECK: begin
        e_want = want_space || want_char;
        e_res.ch = want_space ? SPACE : cc;
      end
      S_EDGE_S: begin
        e_want   = 1'b1;
        e_res.ch = cfg_i.se_pat[8*idx_q +: 8];
      end
      S_EDGE_E: begin
        e_want   = 1'b1;
        e_res.ch = cfg_i.ee_pat[8*idx_q +: 8];
      end
      S_FEND: begin
        e_want     = 1'b1;
        e_res.kind = KIND_FIELD_END;
      end
      S_DONE: begin
        e_want      = 1'b1;
        e_res.kind  = KIND_DONE;
        e_res.count = fc_ext[15:0];
      end
      default: e_want = 1'b0;
    endcase
  end

  // Results past the per-item limit are dropped but still advance the scan.
  assign capped       = (res_cnt_q >= RW'(MAX_RESULTS));
  assign adv          = !e_want || capped || ack_i.em_ready;
  assign cadv         = adv && !want_space;
  assign emit_o.valid = e_want && !capped;
  assign emit_o.fin   = (state_q == S_FIN);
  assign emit_o.res   = e_res;
  assign item_pop_o   = (state_q == S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (item_valid_i) state_d = dis ? S_NEXT : S_PROC;
      S_PROC: begin
        if (phase_q == PH_KEYWORD && kl == '0) state_d = S_PROC;
        else if (phase_q == PH_START && sl == '0) state_d = S_PROC;
        else if (phase_q == PH_CONTENT && el == '0) begin
          state_d = (c_q == NEWLINE) ? S_FEND : S_CONT;
        end else state_d = S_PUSH;
      end
      S_CONT:   if (cadv) state_d = S_NEXT;
      S_PUSH:   if (!full) state_d = S_CHECK;
      S_CHECK: begin
        if (pfx) begin
          if (cnt_q != cur_len) state_d = S_NEXT;
          else if (phase_q == PH_KEYWORD) state_d = S_NEXT;
          else if (phase_q == PH_START) begin
            state_d = (cfg_i.keep_edges && sl != '0) ? S_EDGE_S : S_NEXT;
          end else begin
            state_d = (cfg_i.keep_edges && el != '0) ? S_EDGE_E : S_FEND;
          end
        end
      end
      S_EDGE_S: if (adv && (PW'(idx_q) + PW'(1)) == sl) state_d = S_NEXT;
      S_EDGE_E: if (adv && (PW'(idx_q) + PW'(1)) == el) state_d = S_FEND;
      S_FEND:   if (adv) state_d = flush_q ? S_DONE : S_NEXT;
      S_NEXT: begin
        if (rep_act_q && rep_pos_q < rep_len_q) state_d = S_PROC;
        else if (!last_q) state_d = S_FIN;
        else if (!dis && phase_q == PH_CONTENT) state_d = S_FLUSH;
        else state_d = S_DONE;
      end
      S_FLUSH: begin
        if (cnt_q == '0) state_d = (cfg_i.keep_edges && el != '0) ? S_EDGE_E : S_FEND;
      end
      S_DONE:   if (adv) state_d = S_FIN;
      S_FIN:    if (ack_i.fin_ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and scan state.
  always_comb begin
    phase_d   = phase_q;
    win_d     = win_q;
    rep_d     = rep_q;
    cnt_d     = cnt_q;
    rep_len_d = rep_len_q;
    rep_pos_d = rep_pos_q;
    idx_d     = idx_q;
    ps_d      = ps_q;
    cs_d      = cs_q;
    last_d    = last_q;
    rep_act_d = rep_act_q;
    flush_d   = flush_q;
    c_d       = c_q;
    fcnt_d    = fcnt_q;
    res_cnt_d = res_cnt_q;

    if (e_want && adv && !capped) res_cnt_d = res_cnt_q + RW'(1);

    // Simplify bookkeeping for the content byte.
    if (want_space && adv) ps_d = 1'b0;
    if (cadv && want_char && cfg_i.simplify) cs_d = 1'b1;
    if (cadv && cen && cfg_i.simplify && c_ws && !c_nul && cs_q) ps_d = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          c_d       = item_i.ch;
          last_d    = item_i.last;
          res_cnt_d = '0;
          rep_act_d = 1'b0;
          flush_d   = 1'b0;
        end
      end
      S_PROC: begin
        if (phase_q == PH_KEYWORD && kl == '0) begin
          phase_d = PH_START;
          cnt_d   = '0;
        end else if (phase_q == PH_START && sl == '0) begin
          phase_d = PH_CONTENT;
          cnt_d   = '0;
          ps_d    = 1'b0;
          cs_d    = 1'b0;
        end else if (phase_q == PH_CONTENT && el == '0 && c_q == NEWLINE) begin
          ps_d      = 1'b0;
          rep_d[0]  = NEWLINE;
          rep_len_d = PW'(1);
        end
      end
      S_PUSH, S_CHECK, S_FLUSH: begin
        if ((state_q == S_PUSH && full) || (state_q == S_CHECK && !pfx) ||
            (state_q == S_FLUSH && cnt_q != '0)) begin
          if (cadv) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) win_d[i] = win_q[i+1];
            win_d[MAX_PATTERN-1] = 8'd0;
            cnt_d = cnt_q - PW'(1);
          end
        end else if (state_q == S_PUSH) begin
          win_d[cnt_q[IW-1:0]] = c_q;
          cnt_d = cnt_q + PW'(1);
        end else if (state_q == S_FLUSH) begin
          ps_d  = 1'b0;
          idx_d = '0;
        end else if (cnt_q == cur_len) begin
          idx_d = '0;
          cnt_d = '0;
          if (phase_q == PH_KEYWORD) begin
            phase_d = (sl == '0) ? PH_CONTENT : PH_START;
            ps_d    = 1'b0;
            cs_d    = 1'b0;
          end else if (phase_q == PH_START) begin
            phase_d = PH_CONTENT;
            ps_d    = 1'b0;
            cs_d    = 1'b0;
          end else begin
            rep_d     = win_q;
            rep_len_d = el;
            ps_d      = 1'b0;
            cnt_d     = cnt_q;
          end
        end
      end
      S_EDGE_S, S_EDGE_E: if (adv) idx_d = idx_q + IW'(1);
      S_FEND: begin
        if (adv) begin
          if (fcnt_q != '1) fcnt_d = fcnt_q + COUNT_BITS'(1);
          phase_d   = PH_KEYWORD;
          cnt_d     = '0;
          cs_d      = 1'b0;
          rep_pos_d = '0;
          rep_act_d = !flush_q;
        end
      end
      S_NEXT: begin
        if (rep_act_q && rep_pos_q < rep_len_q) begin
          c_d       = rep_q[rep_pos_q[IW-1:0]];
          rep_pos_d = rep_pos_q + PW'(1);
        end else begin
          rep_act_d = 1'b0;
          flush_d   = last_q && !dis && (phase_q == PH_CONTENT);
        end
      end
      S_DONE: begin
        if (adv) begin
          phase_d = PH_KEYWORD;
          cnt_d   = '0;
          ps_d    = 1'b0;
          cs_d    = 1'b0;
          fcnt_d  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_KEYWORD;
      cnt_q     <= '0;
      ps_q      <= 1'b0;
      cs_q      <= 1'b0;
      fcnt_q    <= '0;
      rep_act_q <= 1'b0;
      flush_q   <= 1'b0;
      res_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      ps_q      <= ps_d;
      cs_q      <= cs_d;
      fcnt_q    <= fcnt_d;
      rep_act_q <= rep_act_d;
      flush_q   <= flush_d;
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q     <= win_d;
    rep_q     <= rep_d;
    rep_len_q <= rep_len_d;
    rep_pos_q <= rep_pos_d;
    idx_q     <= idx_d;
    last_q    <= last_d;
    c_q       <= c_d;
  end

endmodule

>>> design/dfe_outbuf.sv
// ----------------------------------------------------------------------------
// Extractor result buffer
// Holds one result back so the last result of an item can be flagged,
// then presents results through an output register.
// ----------------------------------------------------------------------------
module dfe_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dfe_pkg::dfe_emit_t emit_i,
  output dfe_pkg::dfe_ack_t  ack_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dfe_pkg::dfe_res_t  res_o,
  output logic               run_last_o
);
  import dfe_pkg::*;

  dfe_res_t hold_q, hold_d, out_q, out_d;
  logic     hold_v_q, hold_v_d, out_v_q, out_v_d, last_q, last_d;
  logic     out_free;

  assign out_free        = !out_v_q || out_ready_i;
  assign ack_o.em_ready  = !hold_v_q || out_free;
  assign ack_o.fin_ready = !hold_v_q || out_free;
  assign out_valid_o     = out_v_q;
  assign res_o           = out_q;
  assign run_last_o      = last_q;

  always_comb begin
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    out_d    = out_q;
    last_d   = last_q;
    out_v_d  = out_v_q && !out_ready_i;
    if (emit_i.valid && ack_o.em_ready) begin
      if (hold_v_q) begin
        out_d   = hold_q;
        last_d  = 1'b0;
        out_v_d = 1'b1;
      end
      hold_d   = emit_i.res;
      hold_v_d = 1'b1;
    end else if (emit_i.fin && ack_o.fin_ready && hold_v_q) begin
      // The held result is the final one of its item.
      out_d    = hold_q;
      last_d   = 1'b1;
      out_v_d  = 1'b1;
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

endmodule
